// ----- rtl/cms_pkg.sv -----
package cms_pkg;

    localparam int POSITION_BITS = 16;
    localparam int DWELL_BITS    = 22;

    localparam logic [15:0] SCREW_MIN  = 16'd500;
    localparam logic [15:0] NOZZLE_MIN = 16'd1000;
    localparam logic [15:0] RETURN_MIN = 16'd1000;

    localparam int CFG_ADDR_BITS  = 5;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SCREW_STEP_PERIOD    = 3'd0,
        REG_NOZZLE_STEP_PERIOD   = 3'd1,
        REG_NOZZLE_RETURN_PERIOD = 3'd2,
        REG_DESCEND_STEPS        = 3'd3,
        REG_THREAD_DESCEND_STEPS = 3'd4,
        REG_NOZZLE_STEPS         = 3'd5,
        REG_SETTLE_TICKS         = 3'd6,
        REG_FINAL_DWELL_TICKS    = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic       limit_pressed;
    } t_in_data;

    typedef struct packed {
        logic        screw_step;
        logic        screw_dir_up;
        logic        screw_enable;
        logic        nozzle_step;
        logic        nozzle_dir_close;
        logic        nozzle_enable;
        logic [3:0]  phase_code;
        logic [15:0] position_steps;
        logic        start_rejected;
    } t_out_data;

    typedef struct packed {
        logic [15:0] screw_step_period;
        logic [15:0] nozzle_step_period;
        logic [15:0] nozzle_return_period;
        logic [15:0] descend_steps;
        logic [15:0] thread_descend_steps;
        logic [15:0] nozzle_steps;
        logic [21:0] settle_ticks;
        logic [21:0] final_dwell_ticks;
    } t_cfg;

endpackage

// ----- rtl/capping_motion_sequencer_top.sv -----
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_data)
// output   | out       | o_out_valid / i_out_stall  | o_out_data (t_out_data)
// config   | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One request is taken per clock while o_in_stall is low; its result is registered in the
// output register. The sequencer state and output logic sit between the input handshake
// and that register. A second result register catches a result while the output is
// stalled; o_in_stall is high only while it is occupied.
// Synchronous active-low reset clears the sequencer and loads the default configuration.
module capping_motion_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  cms_pkg::t_in_data                   i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output cms_pkg::t_out_data                  o_out_data,
    input  logic                                i_out_stall,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cms_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import cms_pkg::*;

    t_cfg      w_cfg;
    t_out_data w_result;
    logic      w_accept, w_take;

    logic      r_out_valid, r_skid_valid;
    t_out_data r_out_data, r_skid_data;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_accept    = i_in_valid & ~r_skid_valid;
    assign w_take      = r_out_valid & ~i_out_stall;

    cms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (i_in_data),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (!r_out_valid || w_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_data <= w_result;
            end else begin
                r_skid_data <= w_result;
            end
        end
    end

endmodule

// ----- rtl/cms_cfg_regs.sv -----
module cms_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cms_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output cms_pkg::t_cfg                       o_cfg
);
    import cms_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_index = t_reg_index'(paddr[CFG_ADDR_BITS-1:2]);
    assign w_write = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screw_step_period    <= 16'd1500;
            r_cfg.nozzle_step_period   <= 16'd18000;
            r_cfg.nozzle_return_period <= 16'd6000;
            r_cfg.descend_steps        <= 16'd1600;
            r_cfg.thread_descend_steps <= 16'd120;
            r_cfg.nozzle_steps         <= 16'd200;
            r_cfg.settle_ticks         <= 22'd500000;
            r_cfg.final_dwell_ticks    <= 22'd1000000;
        end else if (w_write) begin
            unique case (w_index)
                REG_SCREW_STEP_PERIOD:    r_cfg.screw_step_period    <= pwdata[15:0];
                REG_NOZZLE_STEP_PERIOD:   r_cfg.nozzle_step_period   <= pwdata[15:0];
                REG_NOZZLE_RETURN_PERIOD: r_cfg.nozzle_return_period <= pwdata[15:0];
                REG_DESCEND_STEPS:        r_cfg.descend_steps        <= pwdata[15:0];
                REG_THREAD_DESCEND_STEPS: r_cfg.thread_descend_steps <= pwdata[15:0];
                REG_NOZZLE_STEPS:         r_cfg.nozzle_steps         <= pwdata[15:0];
                REG_SETTLE_TICKS:         r_cfg.settle_ticks         <= pwdata[21:0];
                REG_FINAL_DWELL_TICKS:    r_cfg.final_dwell_ticks    <= pwdata[21:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_SCREW_STEP_PERIOD:    prdata = 32'(r_cfg.screw_step_period);
            REG_NOZZLE_STEP_PERIOD:   prdata = 32'(r_cfg.nozzle_step_period);
            REG_NOZZLE_RETURN_PERIOD: prdata = 32'(r_cfg.nozzle_return_period);
            REG_DESCEND_STEPS:        prdata = 32'(r_cfg.descend_steps);
            REG_THREAD_DESCEND_STEPS: prdata = 32'(r_cfg.thread_descend_steps);
            REG_NOZZLE_STEPS:         prdata = 32'(r_cfg.nozzle_steps);
            REG_SETTLE_TICKS:         prdata = 32'(r_cfg.settle_ticks);
            REG_FINAL_DWELL_TICKS:    prdata = 32'(r_cfg.final_dwell_ticks);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ----- rtl/cms_core.sv -----
module cms_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  cms_pkg::t_in_data   i_data,
    input  cms_pkg::t_cfg       i_cfg,
    output cms_pkg::t_out_data  o_result
);
    import cms_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_DESCEND = 4'd1,
        PH_SETTLE  = 4'd2,
        PH_THREAD  = 4'd3,
        PH_DWELL   = 4'd4,
        PH_RAISE   = 4'd5,
        PH_RETURN  = 4'd6,
        PH_EMERG   = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [31:0] DWELL_MASK = 32'((64'd1 << DWELL_BITS) - 64'd1);

    t_phase                   r_phase, n_phase;
    logic                     r_emergency, n_emergency;
    logic [15:0]              r_screw_timer, n_screw_timer;
    logic [15:0]              r_nozzle_timer, n_nozzle_timer;
    logic [DWELL_BITS-1:0]    r_dwell_timer, n_dwell_timer;
    logic [15:0]              r_screw_done, n_screw_done;
    logic [15:0]              r_nozzle_done, n_nozzle_done;
    logic [POSITION_BITS-1:0] r_position, n_position;

    t_op         w_op;
    t_phase      w_act;
    logic        w_ss, w_ns, w_rej, w_run;
    logic [15:0] w_sp, w_np, w_rp;
    logic [31:0] w_dwell32, w_settle32, w_final32;

    assign w_op       = t_op'(i_data.operation);
    assign w_sp       = (i_cfg.screw_step_period < SCREW_MIN) ? SCREW_MIN
                                                              : i_cfg.screw_step_period;
    assign w_np       = (i_cfg.nozzle_step_period < NOZZLE_MIN) ? NOZZLE_MIN
                                                                : i_cfg.nozzle_step_period;
    assign w_rp       = (i_cfg.nozzle_return_period < RETURN_MIN) ? RETURN_MIN
                                                                  : i_cfg.nozzle_return_period;
    assign w_dwell32  = 32'(r_dwell_timer);
    assign w_settle32 = 32'(i_cfg.settle_ticks) & DWELL_MASK;
    assign w_final32  = 32'(i_cfg.final_dwell_ticks) & DWELL_MASK;

    always_comb begin
        n_phase        = r_phase;
        n_emergency    = r_emergency;
        n_screw_timer  = r_screw_timer;
        n_nozzle_timer = r_nozzle_timer;
        n_dwell_timer  = r_dwell_timer;
        n_screw_done   = r_screw_done;
        n_nozzle_done  = r_nozzle_done;
        n_position     = r_position;
        w_ss           = 1'b0;
        w_ns           = 1'b0;
        w_rej          = 1'b0;
        w_run          = 1'b0;

        if (w_op == OP_STOP) begin
            n_emergency = 1'b1;
            n_phase     = PH_EMERG;
        end else if (w_op == OP_RESET) begin
            n_emergency    = 1'b0;
            n_phase        = PH_IDLE;
            n_screw_timer  = '0;
            n_nozzle_timer = '0;
            n_dwell_timer  = '0;
            n_screw_done   = '0;
            n_nozzle_done  = '0;
        end else if (w_op == OP_START && (r_phase == PH_IDLE || r_phase == PH_DONE)
                     && !r_emergency && i_data.limit_pressed) begin
            n_phase        = PH_DESCEND;
            n_position     = '0;
            n_screw_timer  = '0;
            n_nozzle_timer = '0;
            n_dwell_timer  = '0;
            n_screw_done   = '0;
            n_nozzle_done  = '0;
        end else begin
            w_run = 1'b1;
            w_rej = (w_op == OP_START);
            case (r_phase)
                PH_DESCEND: begin
                    if (r_screw_timer == '0) begin
                        if (r_screw_done >= i_cfg.descend_steps) begin
                            n_phase       = PH_SETTLE;
                            n_dwell_timer = '0;
                        end else begin
                            w_ss          = 1'b1;
                            n_screw_done  = r_screw_done + 16'd1;
                            if (r_position != POS_MAX) begin
                                n_position = r_position + 1'b1;
                            end
                            n_screw_timer = w_sp - 16'd1;
                        end
                    end else begin
                        n_screw_timer = r_screw_timer - 16'd1;
                    end
                end
                PH_SETTLE: begin
                    if (w_dwell32 >= w_settle32) begin
                        n_phase        = PH_THREAD;
                        n_screw_done   = '0;
                        n_nozzle_done  = '0;
                        n_screw_timer  = w_sp - 16'd1;
                        n_nozzle_timer = w_np - 16'd1;
                    end else begin
                        n_dwell_timer = r_dwell_timer + 1'b1;
                    end
                end
                PH_THREAD: begin
                    if (r_screw_done < i_cfg.thread_descend_steps) begin
                        if (r_screw_timer == '0) begin
                            w_ss          = 1'b1;
                            n_screw_done  = r_screw_done + 16'd1;
                            if (r_position != POS_MAX) begin
                                n_position = r_position + 1'b1;
                            end
                            n_screw_timer = w_sp - 16'd1;
                        end else begin
                            n_screw_timer = r_screw_timer - 16'd1;
                        end
                    end
                    if (r_nozzle_done < i_cfg.nozzle_steps) begin
                        if (r_nozzle_timer == '0) begin
                            w_ns           = 1'b1;
                            n_nozzle_done  = r_nozzle_done + 16'd1;
                            n_nozzle_timer = w_np - 16'd1;
                        end else begin
                            n_nozzle_timer = r_nozzle_timer - 16'd1;
                        end
                    end
                    if (n_screw_done >= i_cfg.thread_descend_steps
                        && n_nozzle_done >= i_cfg.nozzle_steps) begin
                        n_phase       = PH_DWELL;
                        n_dwell_timer = '0;
                    end
                end
                PH_DWELL: begin
                    if (w_dwell32 >= w_final32) begin
                        n_phase       = PH_RAISE;
                        n_screw_timer = '0;
                    end else begin
                        n_dwell_timer = r_dwell_timer + 1'b1;
                    end
                end
                PH_RAISE: begin
                    if (r_screw_timer == '0) begin
                        if (i_data.limit_pressed) begin
                            n_position     = '0;
                            n_phase        = PH_RETURN;
                            n_nozzle_done  = '0;
                            n_nozzle_timer = '0;
                        end else begin
                            w_ss          = 1'b1;
                            if (r_position != '0) begin
                                n_position = r_position - 1'b1;
                            end
                            n_screw_timer = w_sp - 16'd1;
                        end
                    end else begin
                        n_screw_timer = r_screw_timer - 16'd1;
                    end
                end
                PH_RETURN: begin
                    if (r_nozzle_timer == '0) begin
                        if (r_nozzle_done >= i_cfg.nozzle_steps) begin
                            n_phase = PH_DONE;
                        end else begin
                            w_ns           = 1'b1;
                            n_nozzle_done  = r_nozzle_done + 16'd1;
                            n_nozzle_timer = w_rp - 16'd1;
                        end
                    end else begin
                        n_nozzle_timer = r_nozzle_timer - 16'd1;
                    end
                end
                default: ;
            endcase
        end

        w_act = w_run ? r_phase : n_phase;

        o_result.screw_step       = w_ss;
        o_result.screw_dir_up     = (w_act == PH_RAISE);
        o_result.screw_enable     = (w_act == PH_DESCEND) || (w_act == PH_THREAD)
                                    || (w_act == PH_RAISE);
        o_result.nozzle_step      = w_ns;
        o_result.nozzle_dir_close = (w_act == PH_THREAD);
        o_result.nozzle_enable    = (w_act == PH_THREAD) || (w_act == PH_RETURN);
        o_result.phase_code       = n_phase;
        o_result.position_steps   = 16'(n_position);
        o_result.start_rejected   = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_emergency    <= 1'b0;
            r_screw_timer  <= '0;
            r_nozzle_timer <= '0;
            r_dwell_timer  <= '0;
            r_screw_done   <= '0;
            r_nozzle_done  <= '0;
            r_position     <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_emergency    <= n_emergency;
            r_screw_timer  <= n_screw_timer;
            r_nozzle_timer <= n_nozzle_timer;
            r_dwell_timer  <= n_dwell_timer;
            r_screw_done   <= n_screw_done;
            r_nozzle_done  <= n_nozzle_done;
            r_position     <= n_position;
        end
    end

    // The latch is only ever set together with the emergency phase.
    a_latch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emergency |-> (r_phase == PH_EMERG))
        else $error("emergency latched outside the emergency phase");

    a_stop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_op == OP_STOP) |=> (r_phase == PH_EMERG && r_emergency))
        else $error("emergency stop did not latch");

    a_step_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_ss) |-> (r_screw_timer == '0 && o_result.screw_enable))
        else $error("screw step issued before its timer expired");

endmodule
